// ===== design/multilinear_grid_point_interpolator_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MULTILINEAR_GRID_POINT_INTERPOLATOR_CORE_DEFINES_SVH
`define MULTILINEAR_GRID_POINT_INTERPOLATOR_CORE_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define MGPI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mgpi check failed");

// Consequent in the cycle after the antecedent.
`define MGPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mgpi check failed");

`endif

// ===== design/mgpi_pkg.sv =====
package mgpi_pkg;

  localparam int CORNER_W    = 24;
  localparam int NUM_CORNERS = 8;
  localparam int COORD_W     = 4;
  localparam int NUM_COORDS  = 3;
  localparam int FRAC_W      = 16;
  localparam int WEIGHT_W    = FRAC_W + 1;
  localparam int DF_W        = 4;
  localparam int DEN_W       = 4;
  localparam int NUM_W       = COORD_W + FRAC_W;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = WEIGHT_W + 1 + CORNER_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int S_TDATA_W   = 208;
  localparam int M_TDATA_W   = CORNER_W;

  localparam logic [WEIGHT_W-1:0]   FRAC_ONE = 17'h10000;
  localparam logic [2*WEIGHT_W-1:0] W_ROUND  = 34'h8000;
  localparam logic signed [ACC_W-1:0] ACC_ROUND = 44'sd32768;
  localparam logic signed [CORNER_W-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [CORNER_W-1:0] VAL_MIN = 24'sh800000;
  localparam logic [DF_W-1:0] DF_RESET = 4'd2;

  // ceil(2^24 / den): exact quotient for numerators below 2^20
  localparam logic [RECIP_W-1:0] ALPHA_RECIP [16] = '{
    25'd0,
    25'((2**24 + 0) / 1),
    25'((2**24 + 1) / 2),
    25'((2**24 + 2) / 3),
    25'((2**24 + 3) / 4),
    25'((2**24 + 4) / 5),
    25'((2**24 + 5) / 6),
    25'((2**24 + 6) / 7),
    25'((2**24 + 7) / 8),
    25'((2**24 + 8) / 9),
    25'((2**24 + 9) / 10),
    25'((2**24 + 10) / 11),
    25'((2**24 + 11) / 12),
    25'((2**24 + 12) / 13),
    25'((2**24 + 13) / 14),
    25'((2**24 + 14) / 15)
  };

  typedef logic signed [CORNER_W-1:0] value_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef value_t [NUM_CORNERS-1:0] corners_t;
  typedef weight_t [NUM_COORDS-1:0] alphas_t;
  typedef weight_t [NUM_CORNERS-1:0] weights_t;
  typedef logic [NUM_COORDS-1:0][COORD_W-1:0] coords_t;

  typedef struct packed {
    corners_t corners;
    alphas_t  alphas;
    logic     err;
  } alpha_word_t;

  typedef struct packed {
    corners_t corners;
    weights_t weights;
    logic     err;
  } weight_word_t;

endpackage

// ===== design/multilinear_grid_point_interpolator_core.sv =====
// Multilinear grid-point interpolator: each input word carries the 2^DIMS
// corner values of a cell (signed Q7.16) and the integer coordinates of one
// point on a grid with division_factor + 2 points per edge (clamped to
// MAX_EDGE); the output word is the rounded, saturated multilinear
// interpolation at that point, or zero with coord_error set when a used
// coordinate reaches the edge length. The core takes one word per clock and
// returns one word per clock while the output is not stalled; a word passes
// through the chain of registered multipliers (alpha reciprocal, one weight
// stage per dimension, corner products) and the registered adder tree. Output
// back-pressure stalls only the stages that hold data, so bubbles are filled.
// division_factor may be rewritten only while no word is in flight.
module multilinear_grid_point_interpolator_core #(
  parameter int DIMS     = 3,
  parameter int MAX_EDGE = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mgpi_pkg::DF_W-1:0]          cfg_wdata,  // division_factor
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // corner_0..corner_7 [191:0], coord_x [195:192], coord_y [199:196],
  // coord_z [203:200], zero pad [207:204]
  input  logic [mgpi_pkg::S_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mgpi_pkg::M_TDATA_W-1:0]     m_tdata,    // point_value [23:0]
  output logic                               m_tuser     // coord_error [0]
);

  localparam int CW = mgpi_pkg::CORNER_W;
  localparam int XW = mgpi_pkg::COORD_W;
  localparam int COORD_LSB = mgpi_pkg::NUM_CORNERS * CW;

  logic [mgpi_pkg::DF_W-1:0] division_factor;

  mgpi_pkg::corners_t     corners;
  mgpi_pkg::coords_t      coords;
  mgpi_pkg::alpha_word_t  alpha_word;
  mgpi_pkg::weight_word_t weight_word;
  mgpi_pkg::value_t       point_value;
  logic                   alpha_valid, alpha_ready;
  logic                   weight_valid, weight_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      division_factor <= mgpi_pkg::DF_RESET;
    end else if (cfg_we) begin
      division_factor <= cfg_wdata;
    end
  end

  always_comb begin
    for (int j = 0; j < mgpi_pkg::NUM_CORNERS; j++) begin
      corners[j] = s_tdata[j*CW +: CW];
    end
    for (int d = 0; d < mgpi_pkg::NUM_COORDS; d++) begin
      coords[d] = s_tdata[COORD_LSB + d*XW +: XW];
    end
  end

  mgpi_alpha #(
    .DIMS     (DIMS),
    .MAX_EDGE (MAX_EDGE)
  ) u_alpha (
    .clk             (clk),
    .rst             (rst),
    .division_factor (division_factor),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .in_corners      (corners),
    .in_coords       (coords),
    .out_valid       (alpha_valid),
    .out_ready       (alpha_ready),
    .out_word        (alpha_word)
  );

  mgpi_weight #(
    .DIMS (DIMS)
  ) u_weight (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (alpha_valid),
    .in_ready  (alpha_ready),
    .in_word   (alpha_word),
    .out_valid (weight_valid),
    .out_ready (weight_ready),
    .out_word  (weight_word)
  );

  mgpi_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (weight_valid),
    .in_ready    (weight_ready),
    .in_word     (weight_word),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .point_value (point_value),
    .coord_error (m_tuser)
  );

  assign m_tdata = point_value;

endmodule

// ===== design/mgpi_alpha.sv =====
module mgpi_alpha #(
  parameter int DIMS     = 3,
  parameter int MAX_EDGE = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [mgpi_pkg::DF_W-1:0]         division_factor,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mgpi_pkg::corners_t                in_corners,
  input  mgpi_pkg::coords_t                 in_coords,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mgpi_pkg::alpha_word_t             out_word
);

  localparam int LEN_W = $clog2(MAX_EDGE + 1);
  localparam int RAW_W = mgpi_pkg::DF_W + 1;
  localparam int CMP_W = mgpi_pkg::COORD_W + 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_EDGE);

  logic [RAW_W-1:0]              len_raw;
  logic [LEN_W-1:0]              len;
  logic [mgpi_pkg::DEN_W-1:0]    den;
  logic [mgpi_pkg::NUM_COORDS-1:0] err_d;
  mgpi_pkg::alphas_t             alpha_n;

  assign len_raw = {1'b0, division_factor} + RAW_W'(2);
  assign len = (len_raw > RAW_W'(MAX_EDGE)) ? LEN_MAX : LEN_W'(len_raw);
  assign den = mgpi_pkg::DEN_W'(len - LEN_W'(1));

  for (genvar d = 0; d < mgpi_pkg::NUM_COORDS; d++) begin : g_dim
    if (d < DIMS) begin : g_used
      logic [mgpi_pkg::NUM_W-1:0]                     num;
      logic [mgpi_pkg::NUM_W+mgpi_pkg::RECIP_W-1:0]   prod;
      assign err_d[d] = CMP_W'(in_coords[d]) >= CMP_W'(len);
      // round to nearest: add half the divisor before the reciprocal multiply
      assign num  = {in_coords[d], {mgpi_pkg::FRAC_W{1'b0}}} + mgpi_pkg::NUM_W'(den >> 1);
      assign prod = num * mgpi_pkg::ALPHA_RECIP[den];
      assign alpha_n[d] = prod[mgpi_pkg::RECIP_SHIFT +: mgpi_pkg::WEIGHT_W];
    end else begin : g_unused
      assign err_d[d]   = 1'b0;
      assign alpha_n[d] = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_word.corners <= in_corners;
      out_word.alphas  <= alpha_n;
      out_word.err     <= |err_d;
    end
  end

endmodule

// ===== design/mgpi_weight.sv =====
module mgpi_weight #(
  parameter int DIMS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mgpi_pkg::alpha_word_t  in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mgpi_pkg::weight_word_t out_word
);

  localparam int NUM_USED = 1 << DIMS;

  logic               v   [DIMS+1];
  logic               en  [DIMS+2];
  mgpi_pkg::weights_t w   [DIMS+1];
  mgpi_pkg::corners_t cs  [DIMS+1];
  mgpi_pkg::alphas_t  al  [DIMS+1];
  logic               er  [DIMS+1];

  assign v[0]  = in_valid;
  assign w[0]  = {mgpi_pkg::NUM_CORNERS{mgpi_pkg::FRAC_ONE}};
  assign cs[0] = in_word.corners;
  assign al[0] = in_word.alphas;
  assign er[0] = in_word.err;
  assign en[DIMS+1] = out_ready;

  // one stage per dimension: fold alpha or 1 - alpha into every corner weight
  for (genvar k = 1; k <= DIMS; k++) begin : g_stage
    mgpi_pkg::weights_t nxt;

    always_comb begin
      logic [mgpi_pkg::WEIGHT_W-1:0]   f;
      logic [2*mgpi_pkg::WEIGHT_W-1:0] prod;
      for (int j = 0; j < mgpi_pkg::NUM_CORNERS; j++) begin
        f = (((j >> (k - 1)) & 1) != 0) ? al[k-1][k-1]
                                         : mgpi_pkg::FRAC_ONE - al[k-1][k-1];
        prod = w[k-1][j] * f;
        nxt[j] = mgpi_pkg::WEIGHT_W'((prod + mgpi_pkg::W_ROUND) >> mgpi_pkg::FRAC_W);
      end
    end

    assign en[k] = !v[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v[k-1];
      end
      if (en[k]) begin
        w[k]  <= nxt;
        cs[k] <= cs[k-1];
        al[k] <= al[k-1];
        er[k] <= er[k-1];
      end
    end
  end

  assign en[0]    = en[1];
  assign in_ready = en[0];
  assign out_valid = v[DIMS];

  always_comb begin
    out_word.corners = cs[DIMS];
    out_word.err     = er[DIMS];
    for (int j = 0; j < mgpi_pkg::NUM_CORNERS; j++) begin
      // drop corners past 2^DIMS
      out_word.weights[j] = (j < NUM_USED) ? w[DIMS][j] : '0;
    end
  end

endmodule

// ===== design/mgpi_mac.sv =====
module mgpi_mac (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mgpi_pkg::weight_word_t in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mgpi_pkg::value_t       point_value,
  output logic                   coord_error
);

  localparam int NC   = mgpi_pkg::NUM_CORNERS;
  localparam int PW   = mgpi_pkg::PROD_W;
  localparam int AW   = mgpi_pkg::ACC_W;

  logic vp, v1, v2;
  logic ep, e1, e2, e3;
  logic errp, err1, err2;

  logic signed [PW-1:0] prod_n [NC];
  logic signed [PW-1:0] prod   [NC];
  logic signed [AW-1:0] sum4   [NC/2];
  logic signed [AW-1:0] sum2   [2];
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] scaled;
  mgpi_pkg::value_t     sat;

  always_comb begin
    for (int j = 0; j < NC; j++) begin
      prod_n[j] = $signed({1'b0, in_word.weights[j]}) * $signed(in_word.corners[j]);
    end
  end

  assign e3 = !out_valid || out_ready;
  assign e2 = !v2 || e3;
  assign e1 = !v1 || e2;
  assign ep = !vp || e1;
  assign in_ready = ep;

  assign acc    = sum2[0] + sum2[1];
  assign scaled = acc >>> mgpi_pkg::FRAC_W;

  always_comb begin
    priority if (scaled > AW'(mgpi_pkg::VAL_MAX)) begin
      sat = mgpi_pkg::VAL_MAX;
    end else if (scaled < AW'(mgpi_pkg::VAL_MIN)) begin
      sat = mgpi_pkg::VAL_MIN;
    end else begin
      sat = mgpi_pkg::CORNER_W'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ep) begin
        vp <= in_valid;
      end
      if (e1) begin
        v1 <= vp;
      end
      if (e2) begin
        v2 <= v1;
      end
      if (e3) begin
        out_valid <= v2;
      end
    end
    if (ep) begin
      prod <= prod_n;
      errp <= in_word.err;
    end
    if (e1) begin
      for (int i = 0; i < NC / 2; i++) begin
        sum4[i] <= AW'(prod[2*i]) + AW'(prod[2*i+1]);
      end
      err1 <= errp;
    end
    if (e2) begin
      // fold the rounding half into one branch of the tree
      sum2[0] <= sum4[0] + sum4[1];
      sum2[1] <= sum4[2] + sum4[3] + mgpi_pkg::ACC_ROUND;
      err2    <= err1;
    end
    if (e3) begin
      point_value <= err2 ? '0 : sat;
      coord_error <= err2;
    end
  end

endmodule

// ===== design/mgpi_checker.sv =====
`include "multilinear_grid_point_interpolator_core_defines.svh"

module mgpi_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mgpi_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tuser
);

  // a stalled output word holds
  `MGPI_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // reset empties the pipeline
  `MGPI_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid)

  // a coordinate error carries a zero value
  `MGPI_ASSERT_SAME(a_err_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0)

  // with the sink ready the whole pipeline advances
  `MGPI_ASSERT_SAME(a_ready_flow, clk, rst, m_tready, s_tready)

endmodule

bind multilinear_grid_point_interpolator_core mgpi_checker u_mgpi_checker (.*);
